FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge while reset is released.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("checker assertion failed");

// Antecedent implies consequent at the following clock edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    `ASSERT_CLK(label, clk, rst_n, (ante) |=> (cons))

`endif

FILE: rtl/bblc_pkg.sv
// ----------------------------------------------------------------------------
// bblc_pkg
// Types and constants of the byte-budget LRU texture cache.
// ----------------------------------------------------------------------------
package bblc_pkg;

    localparam logic        REG_BUDGET_IDX = 1'b0;
    localparam logic [31:0] BUDGET_RESET   = 32'd268435456;

    typedef struct packed {
        logic [10:0] tex_width;
        logic [10:0] tex_height;
        logic [7:0]  tex_format;
        logic [3:0]  mip_levels;
        logic [63:0] texel_digest;
        logic [1:0]  pal_format;
        logic [14:0] pal_entries;
        logic [63:0] pal_digest;
    } t_key;

    typedef struct packed {
        t_key        key;
        logic [23:0] size;
    } t_entry;

    typedef struct packed {
        logic [10:0] tex_width;
        logic [10:0] tex_height;
        logic [7:0]  tex_format;
        logic [3:0]  mip_levels;
        logic [63:0] texel_digest;
        logic [1:0]  pal_format;
        logic [14:0] pal_entries;
        logic [63:0] pal_digest;
        logic [23:0] entry_bytes;
        logic        may_cache;
    } t_req;

    typedef struct packed {
        logic        hit;
        logic [5:0]  slot;
        logic        stored;
        logic [6:0]  evictions;
        logic [32:0] bytes_in_use;
    } t_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_ADV,
        S_SWEEP,
        S_STAMP,
        S_CHECK,
        S_SCAN2,
        S_DROP,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic load;
        logic scan_start;
        logic take_found;
        logic take_free;
        logic evict_full;
        logic tick;
        logic sweep_start;
        logic write_stamp;
        logic write_entry;
        logic drop_old;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic cacheable;
        logic found;
        logic free_found;
        logic old_found;
        logic fits;
        logic over;
        logic wrap_next;
        logic is_hit;
        logic scan_busy;
        logic sweep_busy;
    } t_dp_sts;

endpackage

FILE: rtl/bblc_req_if.sv
// ----------------------------------------------------------------------------
// bblc_req_if
// Request channel carrying one texture request.
// ----------------------------------------------------------------------------
interface bblc_req_if;
    logic              valid;
    logic              ready;
    bblc_pkg::t_req    data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/bblc_rsp_if.sv
// ----------------------------------------------------------------------------
// bblc_rsp_if
// Response channel carrying one cache lookup result.
// ----------------------------------------------------------------------------
interface bblc_rsp_if;
    logic              valid;
    logic              ready;
    bblc_pkg::t_rsp    data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/bblc_ctrl.sv
// ----------------------------------------------------------------------------
// bblc_ctrl
// Sequencer that steps the datapath through lookup, insertion and eviction.
// ----------------------------------------------------------------------------
module bblc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    input  bblc_pkg::t_dp_sts  i_sts,
    output bblc_pkg::t_dp_cmd  o_cmd
);

    bblc_pkg::t_state r_state, n_state;
    logic             r_out_vld, n_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= bblc_pkg::S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        n_out_vld  = r_out_vld && !i_out_ready;
        unique case (r_state)
            bblc_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load       = 1'b1;
                    o_cmd.scan_start = 1'b1;
                    n_state          = bblc_pkg::S_SCAN;
                end
            end
            bblc_pkg::S_SCAN: begin
                if (!i_sts.scan_busy) begin
                    n_state = bblc_pkg::S_DECIDE;
                end
            end
            bblc_pkg::S_DECIDE: begin
                priority if (!i_sts.cacheable) begin
                    n_state = bblc_pkg::S_RESULT;
                end else if (i_sts.found) begin
                    o_cmd.take_found = 1'b1;
                    n_state          = bblc_pkg::S_ADV;
                end else if (!i_sts.fits) begin
                    n_state = bblc_pkg::S_RESULT;
                end else if (i_sts.free_found) begin
                    o_cmd.take_free = 1'b1;
                    n_state         = bblc_pkg::S_ADV;
                end else begin
                    o_cmd.evict_full = 1'b1;
                    n_state          = bblc_pkg::S_ADV;
                end
            end
            bblc_pkg::S_ADV: begin
                if (i_sts.wrap_next) begin
                    o_cmd.sweep_start = 1'b1;
                    n_state           = bblc_pkg::S_SWEEP;
                end else begin
                    o_cmd.tick = 1'b1;
                    n_state    = bblc_pkg::S_STAMP;
                end
            end
            bblc_pkg::S_SWEEP: begin
                if (!i_sts.sweep_busy) begin
                    n_state = bblc_pkg::S_STAMP;
                end
            end
            bblc_pkg::S_STAMP: begin
                o_cmd.write_stamp = 1'b1;
                if (i_sts.is_hit) begin
                    n_state = bblc_pkg::S_RESULT;
                end else begin
                    o_cmd.write_entry = 1'b1;
                    n_state           = bblc_pkg::S_CHECK;
                end
            end
            bblc_pkg::S_CHECK: begin
                if (i_sts.over) begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = bblc_pkg::S_SCAN2;
                end else begin
                    n_state = bblc_pkg::S_RESULT;
                end
            end
            bblc_pkg::S_SCAN2: begin
                if (!i_sts.scan_busy) begin
                    n_state = i_sts.old_found ? bblc_pkg::S_DROP : bblc_pkg::S_RESULT;
                end
            end
            bblc_pkg::S_DROP: begin
                o_cmd.drop_old = 1'b1;
                n_state        = bblc_pkg::S_CHECK;
            end
            bblc_pkg::S_RESULT: begin
                if (!r_out_vld || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_vld      = 1'b1;
                    n_state        = bblc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bblc_pkg::S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_vld;

endmodule

FILE: rtl/bblc_dp.sv
// ----------------------------------------------------------------------------
// bblc_dp
// Slot memories, slot scanner, recency clock and byte accounting.
// ----------------------------------------------------------------------------
module bblc_dp #(
    parameter int SLOTS      = 64,
    parameter int STAMP_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bblc_pkg::t_dp_cmd  i_cmd,
    output bblc_pkg::t_dp_sts  o_sts,
    input  bblc_pkg::t_req     i_req,
    input  logic [31:0]        i_budget,
    output bblc_pkg::t_rsp     o_rsp
);

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    bblc_pkg::t_entry        key_mem   [SLOTS];
    logic [STAMP_BITS-1:0]   stamp_mem [SLOTS];

    logic [SLOTS-1:0]        r_valid;
    bblc_pkg::t_key          r_key;
    logic [23:0]             r_size;
    logic                    r_cacheable;

    logic                    r_scan_act;
    logic [CW-1:0]           r_scan_addr;
    logic                    r_pipe_vld;
    logic [IW-1:0]           r_pipe_idx;
    bblc_pkg::t_entry        r_rd_entry;
    logic [STAMP_BITS-1:0]   r_rd_stamp;

    logic                    r_found, r_free_found, r_old_found;
    logic [IW-1:0]           r_found_idx, r_free_idx, r_old_idx;
    logic [STAMP_BITS-1:0]   r_old_stamp;
    logic [23:0]             r_old_size;

    logic                    r_sw_act;
    logic [IW-1:0]           r_sw_addr;

    logic [STAMP_BITS-1:0]   r_clock;
    logic [32:0]             r_used;
    logic [IW-1:0]           r_tgt;
    logic                    r_hit, r_stored;
    logic [6:0]              r_evict;
    bblc_pkg::t_rsp          r_rsp;

    logic                    scan_rd;
    logic                    eval_v;
    bblc_pkg::t_key          req_key;

    assign scan_rd = r_scan_act && (r_scan_addr != CW'(SLOTS));
    assign eval_v  = r_valid[r_pipe_idx];

    always_comb begin
        req_key.tex_width    = i_req.tex_width;
        req_key.tex_height   = i_req.tex_height;
        req_key.tex_format   = i_req.tex_format;
        req_key.mip_levels   = i_req.mip_levels;
        req_key.texel_digest = i_req.texel_digest;
        req_key.pal_format   = i_req.pal_format;
        req_key.pal_entries  = i_req.pal_entries;
        req_key.pal_digest   = i_req.pal_digest;
    end

    always_ff @(posedge i_clk) begin
        if (scan_rd) begin
            r_rd_entry <= key_mem[r_scan_addr[IW-1:0]];
        end
        if (i_cmd.write_entry) begin
            key_mem[r_tgt] <= '{key: r_key, size: r_size};
        end
    end

    always_ff @(posedge i_clk) begin
        if (scan_rd) begin
            r_rd_stamp <= stamp_mem[r_scan_addr[IW-1:0]];
        end
        if (r_sw_act) begin
            stamp_mem[r_sw_addr] <= '0;
        end else if (i_cmd.write_stamp) begin
            stamp_mem[r_tgt] <= r_clock;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key       <= req_key;
            r_size      <= i_req.entry_bytes;
            r_cacheable <= i_req.may_cache;
        end
        r_pipe_idx <= r_scan_addr[IW-1:0];
        if (i_cmd.out_load) begin
            r_rsp.hit          <= r_hit;
            r_rsp.slot         <= (r_hit || r_stored) ? 6'(r_tgt) : '0;
            r_rsp.stored       <= r_stored;
            r_rsp.evictions    <= r_evict;
            r_rsp.bytes_in_use <= r_used;
        end
        if (i_cmd.scan_start) begin
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
            r_old_found  <= 1'b0;
        end else if (r_pipe_vld) begin
            if (eval_v && (r_rd_entry.key == r_key) && !r_found) begin
                r_found     <= 1'b1;
                r_found_idx <= r_pipe_idx;
            end
            if (!eval_v && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free_idx   <= r_pipe_idx;
            end
            if (eval_v && (!r_old_found || (r_rd_stamp < r_old_stamp))) begin
                r_old_found <= 1'b1;
                r_old_idx   <= r_pipe_idx;
                r_old_stamp <= r_rd_stamp;
                r_old_size  <= r_rd_entry.size;
            end
        end
        if (i_cmd.take_found) begin
            r_tgt <= r_found_idx;
        end else if (i_cmd.take_free) begin
            r_tgt <= r_free_idx;
        end else if (i_cmd.evict_full) begin
            r_tgt <= r_old_idx;
        end
        if (i_cmd.load) begin
            r_hit    <= 1'b0;
            r_stored <= 1'b0;
            r_evict  <= '0;
        end else begin
            if (i_cmd.take_found) begin
                r_hit <= 1'b1;
            end
            if (i_cmd.write_entry) begin
                r_stored <= 1'b1;
            end
            if (i_cmd.evict_full || i_cmd.drop_old) begin
                r_evict <= r_evict + 7'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_scan_act  <= 1'b0;
            r_scan_addr <= '0;
            r_pipe_vld  <= 1'b0;
            r_sw_act    <= 1'b0;
            r_sw_addr   <= '0;
            r_clock     <= '0;
            r_used      <= '0;
        end else begin
            if (i_cmd.scan_start) begin
                r_scan_act  <= 1'b1;
                r_scan_addr <= '0;
                r_pipe_vld  <= 1'b0;
            end else if (r_scan_act) begin
                r_pipe_vld <= scan_rd;
                if (scan_rd) begin
                    r_scan_addr <= r_scan_addr + CW'(1);
                end else if (!r_pipe_vld) begin
                    r_scan_act <= 1'b0;
                end
            end
            if (i_cmd.sweep_start) begin
                r_sw_act  <= 1'b1;
                r_sw_addr <= '0;
            end else if (r_sw_act) begin
                if (r_sw_addr == IW'(SLOTS - 1)) begin
                    r_sw_act <= 1'b0;
                    r_clock  <= STAMP_BITS'(1);
                end else begin
                    r_sw_addr <= r_sw_addr + IW'(1);
                end
            end else if (i_cmd.tick) begin
                r_clock <= r_clock + STAMP_BITS'(1);
            end
            if (i_cmd.evict_full || i_cmd.drop_old) begin
                r_valid[r_old_idx] <= 1'b0;
                r_used             <= r_used - {9'd0, r_old_size};
            end else if (i_cmd.write_entry) begin
                r_valid[r_tgt] <= 1'b1;
                r_used         <= r_used + {9'd0, r_size};
            end
        end
    end

    always_comb begin
        o_sts.cacheable  = r_cacheable;
        o_sts.found      = r_found;
        o_sts.free_found = r_free_found;
        o_sts.old_found  = r_old_found;
        o_sts.fits       = {8'd0, r_size} <= i_budget;
        o_sts.over       = r_used > {1'b0, i_budget};
        o_sts.wrap_next  = &r_clock;
        o_sts.is_hit     = r_hit;
        o_sts.scan_busy  = r_scan_act;
        o_sts.sweep_busy = r_sw_act;
    end

    assign o_rsp = r_rsp;

endmodule

FILE: rtl/byte_budget_lru_texture_cache.sv
// ----------------------------------------------------------------------------
// byte_budget_lru_texture_cache
// Texture cache with least-recently-used replacement under a byte budget.
// ----------------------------------------------------------------------------
// One request is handled at a time. Every request walks all slots once for
// the key search. After the walk a hit passes the advance and stamp states
// and an insertion also a budget check before the result is registered, and
// the block then returns to idle before it takes the next request. When the
// recency clock wraps, a sweep clears the stamp memory first. Each eviction
// needed after an insertion to get back under the budget costs another walk
// plus a drop and a budget check. The slot memories have a single read port,
// so the walk reads one slot at a time. The result sits in an output
// register, so a new request is taken while the previous result waits.
module byte_budget_lru_texture_cache #(
    parameter int SLOTS      = 64,
    parameter int STAMP_BITS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bblc_req_if.sink      i_req,
    bblc_rsp_if.source    o_rsp,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    logic [31:0]        r_budget;
    bblc_pkg::t_dp_cmd  cmd;
    bblc_pkg::t_dp_sts  sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_budget <= bblc_pkg::BUDGET_RESET;
        end else if (psel && penable && pwrite && pready
                     && (paddr[2] == bblc_pkg::REG_BUDGET_IDX)) begin
            r_budget <= pwdata;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == bblc_pkg::REG_BUDGET_IDX) ? r_budget : '0;

    bblc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (o_rsp.valid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    bblc_dp #(
        .SLOTS      (SLOTS),
        .STAMP_BITS (STAMP_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .i_req    (i_req.data),
        .i_budget (r_budget),
        .o_rsp    (o_rsp.data)
    );

endmodule

FILE: rtl/bblc_checker.sv
// ----------------------------------------------------------------------------
// bblc_checker
// Port-level checks of the texture cache, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bblc_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    input  logic            i_req_ready,
    input  logic            i_rsp_valid,
    input  logic            i_rsp_ready,
    input  bblc_pkg::t_rsp  i_rsp
);

    `ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid)
    `ASSERT_NEXT(a_one_request, i_clk, i_rst_n, i_req_valid && i_req_ready, !i_req_ready)
    `ASSERT_CLK(a_hit_xor_store, i_clk, i_rst_n, i_rsp_valid |-> !(i_rsp.hit && i_rsp.stored))
    `ASSERT_CLK(a_evict_needs_store, i_clk, i_rst_n, (i_rsp_valid && !i_rsp.stored) |-> (i_rsp.evictions == 7'd0))

endmodule

bind byte_budget_lru_texture_cache bblc_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp       (o_rsp.data)
);
